@@ design/uft_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// uft_pkg
// Shared types and codes of the UDP flow table.
// ---------------------------------------------------------------------------
package uft_pkg;

    localparam int MAX_FLOWS = 64;
    localparam int IDX_W     = $clog2(MAX_FLOWS);
    localparam int CNT_W     = $clog2(MAX_FLOWS + 1);

    localparam logic [1:0] CMD_LOCAL  = 2'd0;
    localparam logic [1:0] CMD_BROKER = 2'd1;
    localparam logic [1:0] CMD_SWEEP  = 2'd2;

    localparam logic [1:0] ACT_DROP   = 2'd0;
    localparam logic [1:0] ACT_BROKER = 2'd1;
    localparam logic [1:0] ACT_LOCAL  = 2'd2;
    localparam logic [1:0] ACT_SWEEP  = 2'd3;

    localparam logic [2:0] RSN_NONE    = 3'd0;
    localparam logic [2:0] RSN_DISABLE = 3'd1;
    localparam logic [2:0] RSN_LONG    = 3'd2;
    localparam logic [2:0] RSN_EMPTY   = 3'd3;
    localparam logic [2:0] RSN_FULL    = 3'd4;
    localparam logic [2:0] RSN_UNKNOWN = 3'd5;

    localparam logic [1:0] REG_ENABLE  = 2'd0;
    localparam logic [1:0] REG_MAXDG   = 2'd1;
    localparam logic [1:0] REG_MAXFL   = 2'd2;
    localparam logic [1:0] REG_TIMEOUT = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,   // waiting for a beat
        ST_SCAN,   // walking the table for a match
        ST_IDCHK,  // checking a candidate id against the table
        ST_WRITE,  // writing the new or refreshed entry
        ST_SWEEP,  // walking the table removing idle entries
        ST_OUT     // result waiting to be taken
    } state_t;

    // One table entry as stored in memory.
    typedef struct packed {
        logic [63:0] id;
        logic [63:0] addr_high;
        logic [63:0] addr_low;
        logic [15:0] port;
        logic        family;
        logic [47:0] last_seen;
    } entry_t;

endpackage
`default_nettype wire

@@ design/udp_flow_table.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// udp_flow_table
// Flow table of a UDP relay: maps local endpoints to flow ids with idle aging.
// ---------------------------------------------------------------------------
// The entries live in one synchronous memory that is read one entry per cycle,
// so each beat that is not dropped at once costs a walk of the table. A local
// or broker datagram that is routed scans all MAX_FLOWS entries before its
// result is presented, and so does a drop found by the scan (an unknown flow
// id or a full table). A new local flow adds one further scan of the table for
// every candidate id checked, the first one included. A sweep tick walks the
// table before its result is presented. Drops decided from the beat alone
// present their result in the cycle after the beat is taken. One beat is
// handled at a time; the result sits in an output register, and the next beat
// is taken only after the result has left and the state has returned to idle.
// Valid bits are flip-flops cleared at reset, so no clearing pass is needed.
// ---------------------------------------------------------------------------
module udp_flow_table
    import uft_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // configuration writes
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [31:0]  cfg_data,
    // input beats
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // tdata, low bit up: cmd[1:0], now_ms[49:2], src_is_v6[50],
    // src_addr_high[114:51], src_addr_low[178:115], src_port[194:179],
    // flow_id[258:195], payload_len[274:259], zero fill to 280 bits
    input  wire logic [279:0] s_tdata,
    // result beats
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // tdata, low bit up: action[1:0], drop_reason[4:2], out_flow_id[68:5],
    // dest_is_v6[69], dest_addr_high[133:70], dest_addr_low[197:134],
    // dest_port[213:198], new_flow[214], closed_count[221:215], zero fill to 224
    output logic [223:0]      m_tdata
);

    // Configuration registers.
    logic        enable_reg;
    logic [15:0] maxdg_reg;
    logic [6:0]  maxfl_reg;
    logic [31:0] timeout_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg  <= 1'b0;
            maxdg_reg   <= 16'd1200;
            maxfl_reg   <= 7'd64;
            timeout_reg <= 32'd60000;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_ENABLE:  enable_reg  <= cfg_data[0];
                REG_MAXDG:   maxdg_reg   <= cfg_data[15:0];
                REG_MAXFL:   maxfl_reg   <= cfg_data[6:0];
                REG_TIMEOUT: timeout_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input fields.
    wire logic [1:0]  in_cmd  = s_tdata[1:0];
    wire logic [47:0] in_now  = s_tdata[49:2];
    wire logic        in_fam  = s_tdata[50];
    wire logic [63:0] in_hi   = s_tdata[114:51];
    wire logic [63:0] in_lo   = s_tdata[178:115];
    wire logic [15:0] in_port = s_tdata[194:179];
    wire logic [63:0] in_fid  = s_tdata[258:195];
    wire logic [15:0] in_len  = s_tdata[274:259];

    // Latched beat; IPv4 addresses are normalised on capture.
    logic [1:0]  cmd_reg;
    logic [47:0] now_reg;
    logic        fam_reg;
    logic [63:0] hi_reg, lo_reg, fid_reg;
    logic [15:0] port_reg;

    // Table storage.
    entry_t                 mem [MAX_FLOWS];
    entry_t                 rd_reg;
    logic [MAX_FLOWS-1:0]   valid_reg, valid_next;
    logic [IDX_W-1:0]       raddr;
    logic                   mem_we;
    logic [IDX_W-1:0]       waddr;
    entry_t                 wdata;

    always_ff @(posedge aclk) begin
        if (mem_we) mem[waddr] <= wdata;
        rd_reg <= mem[raddr];
    end

    // Walk control.
    state_t          state_reg, state_next;
    logic [CNT_W-1:0] ptr_reg, ptr_next;     // address issued
    logic            rdv_reg, rdv_next;      // rd_reg holds entry ptr_reg-1
    logic [IDX_W-1:0] rdi_reg;               // index of rd_reg
    logic            hit_reg, hit_next;
    logic [IDX_W-1:0] hiti_reg, hiti_next;
    logic            free_reg, free_next;
    logic [IDX_W-1:0] freei_reg, freei_next;
    logic [63:0]     nid_reg, nid_next;      // next id counter
    logic [63:0]     cand_reg, cand_next;    // candidate id under check
    logic [6:0]      fcnt_reg, fcnt_next;
    logic [6:0]      closed_reg, closed_next;

    // Output register.
    logic [223:0]    out_reg, out_next;
    logic            ov_reg;

    logic [6:0]  cap;
    assign cap = (maxfl_reg < 7'(MAX_FLOWS)) ? maxfl_reg : 7'(MAX_FLOWS);

    wire logic [IDX_W-1:0] ptr_idx = ptr_reg[IDX_W-1:0];
    wire logic walk_done = (ptr_reg == CNT_W'(MAX_FLOWS));
    wire logic rd_ok = rdv_reg && valid_reg[rdi_reg];

    wire logic src_match = rd_ok && rd_reg.family == fam_reg
        && rd_reg.addr_high == hi_reg && rd_reg.addr_low == lo_reg
        && rd_reg.port == port_reg;
    wire logic id_match = rd_ok && rd_reg.id == ((state_reg == ST_IDCHK) ? cand_reg
                                                                        : fid_reg);
    wire logic [47:0] age = now_reg - rd_reg.last_seen;
    wire logic aged = rd_ok && (age > {16'd0, timeout_reg});

    function automatic logic [223:0] pack_out(logic [1:0] act, logic [2:0] rsn,
                                              logic [63:0] fid, entry_t e,
                                              logic use_dest, logic nf,
                                              logic [6:0] cc);
        logic [223:0] v;
        v = '0;
        v[1:0] = act;
        v[4:2] = rsn;
        v[68:5] = fid;
        if (use_dest) begin
            v[69]      = e.family;
            v[133:70]  = e.addr_high;
            v[197:134] = e.addr_low;
            v[213:198] = e.port;
        end
        v[214] = nf;
        v[221:215] = cc;
        return v;
    endfunction

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && s_tready) begin
                    if (in_cmd == CMD_SWEEP) state_next = ST_SWEEP;
                    else if (in_cmd == CMD_LOCAL && in_len != 16'd0 && enable_reg
                             && in_len <= maxdg_reg) state_next = ST_SCAN;
                    else if (in_cmd == CMD_BROKER && enable_reg && in_fid != 64'd0
                             && in_len <= maxdg_reg) state_next = ST_SCAN;
                    else state_next = ST_OUT;
                end
            end
            ST_SCAN: begin
                if (walk_done && !rdv_reg) begin
                    if (cmd_reg == CMD_BROKER) state_next = hit_reg ? ST_WRITE : ST_OUT;
                    else if (hit_reg) state_next = ST_WRITE;
                    else if (fcnt_reg >= cap || !free_reg) state_next = ST_OUT;
                    else state_next = ST_IDCHK;
                end
            end
            ST_IDCHK: begin
                if (walk_done && !rdv_reg && !hit_reg) state_next = ST_WRITE;
            end
            ST_WRITE: state_next = ST_OUT;
            ST_SWEEP: if (walk_done && !rdv_reg) state_next = ST_OUT;
            ST_OUT:   if (!ov_reg) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb begin
        ptr_next    = ptr_reg;
        rdv_next    = 1'b0;
        hit_next    = hit_reg;
        hiti_next   = hiti_reg;
        free_next   = free_reg;
        freei_next  = freei_reg;
        nid_next    = nid_reg;
        cand_next   = cand_reg;
        fcnt_next   = fcnt_reg;
        closed_next = closed_reg;
        valid_next  = valid_reg;
        out_next    = out_reg;
        raddr       = ptr_idx;
        mem_we      = 1'b0;
        waddr       = hiti_reg;
        wdata       = rd_reg;
        case (state_reg)
            ST_IDLE: begin
                ptr_next = '0; hit_next = 1'b0; free_next = 1'b0; closed_next = '0;
                if (s_tvalid && s_tready) begin
                    if (in_cmd == CMD_LOCAL) begin
                        if (in_len == 16'd0)
                            out_next = pack_out(ACT_DROP, RSN_EMPTY, '0, rd_reg,
                                                1'b0, 1'b0, 7'd0);
                        else if (!enable_reg)
                            out_next = pack_out(ACT_DROP, RSN_DISABLE, '0, rd_reg,
                                                1'b0, 1'b0, 7'd0);
                        else
                            out_next = pack_out(ACT_DROP, RSN_LONG, '0, rd_reg,
                                                1'b0, 1'b0, 7'd0);
                    end else if (in_cmd == CMD_BROKER) begin
                        if (!enable_reg)
                            out_next = pack_out(ACT_DROP, RSN_DISABLE, '0, rd_reg,
                                                1'b0, 1'b0, 7'd0);
                        else if (in_fid == 64'd0)
                            out_next = pack_out(ACT_DROP, RSN_EMPTY, '0, rd_reg,
                                                1'b0, 1'b0, 7'd0);
                        else
                            out_next = pack_out(ACT_DROP, RSN_LONG, '0, rd_reg,
                                                1'b0, 1'b0, 7'd0);
                    end else begin
                        out_next = '0;
                    end
                end
            end
            ST_SCAN, ST_SWEEP, ST_IDCHK: begin
                if (!walk_done) begin
                    ptr_next = ptr_reg + 1'b1;
                    rdv_next = 1'b1;
                end
                if (rdv_reg) begin
                    if (state_reg == ST_SWEEP) begin
                        if (aged) begin
                            valid_next[rdi_reg] = 1'b0;
                            if (fcnt_next != 7'd0) fcnt_next = fcnt_next - 1'b1;
                            if (closed_next != 7'd127) closed_next = closed_next + 1'b1;
                        end
                    end else if ((cmd_reg == CMD_LOCAL && state_reg == ST_SCAN)
                                 ? src_match : id_match) begin
                        if (!hit_reg) begin
                            hit_next = 1'b1; hiti_next = rdi_reg;
                        end
                    end
                    if (state_reg == ST_SCAN && !valid_reg[rdi_reg] && !free_reg) begin
                        free_next = 1'b1; freei_next = rdi_reg;
                    end
                end
                if (walk_done && !rdv_reg) begin
                    ptr_next = '0;
                    if (state_reg == ST_SWEEP) begin
                        out_next = pack_out(ACT_SWEEP, RSN_NONE, '0, rd_reg, 1'b0, 1'b0,
                                            closed_reg);
                    end else if (state_reg == ST_SCAN) begin
                        if (cmd_reg == CMD_BROKER && !hit_reg)
                            out_next = pack_out(ACT_DROP, RSN_UNKNOWN, '0, rd_reg,
                                                1'b0, 1'b0, 7'd0);
                        else if (cmd_reg == CMD_LOCAL && !hit_reg) begin
                            if (fcnt_reg >= cap || !free_reg)
                                out_next = pack_out(ACT_DROP, RSN_FULL, '0, rd_reg,
                                                    1'b0, 1'b0, 7'd0);
                            else begin
                                // take the next nonzero id
                                cand_next = (nid_reg == 64'd0) ? 64'd1 : nid_reg;
                                nid_next  = cand_next + 64'd1;
                            end
                        end
                        raddr = hiti_reg;
                    end else begin
                        if (hit_reg) begin
                            hit_next  = 1'b0;
                            cand_next = (nid_reg == 64'd0) ? 64'd1 : nid_reg;
                            nid_next  = cand_next + 64'd1;
                        end
                    end
                end
            end
            ST_WRITE: begin
                if (cmd_reg == CMD_LOCAL && !hit_reg) begin
                    waddr = freei_reg;
                    wdata.id = cand_reg;
                    wdata.family = fam_reg;
                    wdata.addr_high = hi_reg;
                    wdata.addr_low = lo_reg;
                    wdata.port = port_reg;
                    valid_next[freei_reg] = 1'b1;
                    fcnt_next = fcnt_reg + 1'b1;
                    out_next = pack_out(ACT_BROKER, RSN_NONE, cand_reg, rd_reg,
                                        1'b0, 1'b1, 7'd0);
                end else if (cmd_reg == CMD_LOCAL) begin
                    out_next = pack_out(ACT_BROKER, RSN_NONE, rd_reg.id, rd_reg,
                                        1'b0, 1'b0, 7'd0);
                end else begin
                    out_next = pack_out(ACT_LOCAL, RSN_NONE, rd_reg.id, rd_reg,
                                        1'b1, 1'b0, 7'd0);
                end
                wdata.last_seen = now_reg;
                mem_we = 1'b1;
            end
            default: ;
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = ov_reg;
    assign m_tdata  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            valid_reg <= '0;
            nid_reg   <= 64'd1;
            fcnt_reg  <= '0;
            ov_reg    <= 1'b0;
            rdv_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            nid_reg   <= nid_next;
            fcnt_reg  <= fcnt_next;
            rdv_reg   <= rdv_next;
            if (m_tvalid && m_tready) ov_reg <= 1'b0;
            else if (state_reg != ST_OUT && state_next == ST_OUT) ov_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        ptr_reg    <= ptr_next;
        rdi_reg    <= ptr_idx;
        hit_reg    <= hit_next;
        hiti_reg   <= hiti_next;
        free_reg   <= free_next;
        freei_reg  <= freei_next;
        cand_reg   <= cand_next;
        closed_reg <= closed_next;
        out_reg    <= out_next;
        if (s_tvalid && s_tready) begin
            cmd_reg  <= in_cmd;
            now_reg  <= in_now;
            fam_reg  <= in_fam;
            hi_reg   <= in_fam ? in_hi : 64'd0;
            lo_reg   <= in_fam ? in_lo : {32'd0, in_lo[31:0]};
            port_reg <= in_port;
            fid_reg  <= in_fid;
        end
    end

    // The flow count never exceeds the table depth.
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        fcnt_reg <= 7'(MAX_FLOWS)) else $error("flow count overflow");
    // No beat is taken while a result is pending.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("input taken with result pending");
    // A new entry is written only into a free slot.
    a_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WRITE && cmd_reg == CMD_LOCAL && !hit_reg)
        |-> !valid_reg[freei_reg]) else $error("allocation over a live entry");
    // A stalled result holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(m_tdata)) else $error("result changed");

endmodule
`default_nettype wire
